/* src/leb_pkg.sv */
// Shared types, codes and constants for the line edit buffer.
package leb_pkg;

  localparam int MAX_LINE_DEF = 64;

  localparam int LEN_W  = 7;
  localparam int CODE_W = 21;
  localparam int POS_W  = 6;
  localparam int KIND_W = 4;
  localparam int CIDX_W = 2;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 7'd64;

  localparam logic [CODE_W-1:0] SPACE_CODE = 21'h20;
  localparam logic [CODE_W-1:0] QMARK_CODE = 21'h3f;
  localparam logic [CODE_W-1:0] LOWER_LO   = 21'h60;
  localparam logic [CODE_W-1:0] LOWER_HI   = 21'h7b;
  localparam logic [CODE_W-1:0] PRINT_MIN  = 21'd32;
  localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10ffff;
  localparam logic [CODE_W-1:0] BYTE_MAX   = 21'hff;

  // key kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 4'd0;
  localparam logic [KIND_W-1:0] KIND_BSPACE = 4'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 4'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_HOME   = 4'd6;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_WLEFT  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_WRIGHT = 4'd9;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 4'd10;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 4'd11;
  localparam logic [KIND_W-1:0] KIND_START  = 4'd12;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_MAX_LENGTH = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_CAPS_LOCK  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BYTE_MODE  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_CLEAR,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_INS_INIT,
    OP_INS_FIN,
    OP_BS_INIT,
    OP_DEL_INIT,
    OP_BS_FIN,
    OP_DEL_FIN,
    OP_UP_RD,
    OP_UP_WR,
    OP_DN_RD,
    OP_DN_WR,
    OP_SK_RD,
    OP_SK_STEP,
    OP_STOP,
    OP_ST_RD,
    OP_EMIT_ST,
    OP_EMIT_CH
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_WR,
    S_DN_CHK,
    S_DN_WR,
    S_SK1,
    S_SK1C,
    S_SK2,
    S_SK2C,
    S_WFIN,
    S_STATUS,
    S_ST_RD,
    S_ST_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ign_we;
    logic ign_val;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              active;
    logic              len_zero;
    logic              cur_zero;
    logic              cur_ge_len;
    logic              ins_bad;
    logic              idx_gt_cur;
    logic              idx_lt_len;
    logic              idx_last;
    logic              skip_can;
    logic              skip1_match;
    logic              cur_eq_old;
    logic              out_free;
  } stat_t;

  typedef struct packed {
    logic [LEN_W-1:0] max_length;
    logic             caps_lock;
    logic             byte_mode;
  } cfg_t;

endpackage

/* src/leb_ctrl.sv */
// Controller state machine: decodes each key and sequences the datapath.
module leb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  leb_pkg::stat_t  st,
  output leb_pkg::cmd_t   cmd
);

  leb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= leb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      leb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = leb_pkg::S_DISPATCH;
      end
      leb_pkg::S_DISPATCH: begin
        state_nxt = leb_pkg::S_STATUS;
        if (st.kind != leb_pkg::KIND_START && st.active) begin
          case (st.kind)
            leb_pkg::KIND_INSERT: begin
              if (!st.ins_bad) state_nxt = leb_pkg::S_UP_CHK;
            end
            leb_pkg::KIND_BSPACE: begin
              if (!st.len_zero && !st.cur_zero) state_nxt = leb_pkg::S_DN_CHK;
            end
            leb_pkg::KIND_DELETE: begin
              if (!st.len_zero && !st.cur_ge_len) state_nxt = leb_pkg::S_DN_CHK;
            end
            leb_pkg::KIND_WLEFT, leb_pkg::KIND_WRIGHT: state_nxt = leb_pkg::S_SK1;
            leb_pkg::KIND_ACCEPT, leb_pkg::KIND_CANCEL: begin
              if (!st.len_zero) state_nxt = leb_pkg::S_ST_RD;
            end
            default: state_nxt = leb_pkg::S_STATUS;
          endcase
        end
      end
      leb_pkg::S_UP_CHK: begin
        state_nxt = st.idx_gt_cur ? leb_pkg::S_UP_WR : leb_pkg::S_STATUS;
      end
      leb_pkg::S_UP_WR: state_nxt = leb_pkg::S_UP_CHK;
      leb_pkg::S_DN_CHK: begin
        state_nxt = st.idx_lt_len ? leb_pkg::S_DN_WR : leb_pkg::S_STATUS;
      end
      leb_pkg::S_DN_WR: state_nxt = leb_pkg::S_DN_CHK;
      leb_pkg::S_SK1: begin
        state_nxt = st.skip_can ? leb_pkg::S_SK1C : leb_pkg::S_WFIN;
      end
      // a character that ends the first run already counts toward the second
      leb_pkg::S_SK1C: state_nxt = st.skip1_match ? leb_pkg::S_SK1 : leb_pkg::S_SK2;
      leb_pkg::S_SK2: begin
        state_nxt = st.skip_can ? leb_pkg::S_SK2C : leb_pkg::S_WFIN;
      end
      leb_pkg::S_SK2C: state_nxt = st.skip1_match ? leb_pkg::S_WFIN : leb_pkg::S_SK2;
      leb_pkg::S_WFIN: state_nxt = leb_pkg::S_STATUS;
      leb_pkg::S_STATUS: begin
        if (st.out_free) state_nxt = leb_pkg::S_IDLE;
      end
      leb_pkg::S_ST_RD: state_nxt = leb_pkg::S_ST_EMIT;
      leb_pkg::S_ST_EMIT: begin
        if (st.out_free) state_nxt = st.idx_last ? leb_pkg::S_IDLE : leb_pkg::S_ST_RD;
      end
      default: state_nxt = leb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '{op: leb_pkg::OP_NONE, ign_we: 1'b0, ign_val: 1'b0};
    in_ready = 1'b0;
    case (state_r)
      leb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = leb_pkg::OP_LOAD;
      end
      leb_pkg::S_DISPATCH: begin
        cmd.ign_we  = 1'b1;
        cmd.ign_val = 1'b1;
        if (st.kind == leb_pkg::KIND_START) begin
          cmd.op      = leb_pkg::OP_START;
          cmd.ign_val = 1'b0;
        end else if (st.active) begin
          case (st.kind)
            leb_pkg::KIND_INSERT: begin
              if (!st.ins_bad) begin
                cmd.op      = leb_pkg::OP_INS_INIT;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_BSPACE: begin
              if (!st.len_zero && !st.cur_zero) begin
                cmd.op      = leb_pkg::OP_BS_INIT;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_DELETE: begin
              if (!st.len_zero && !st.cur_ge_len) begin
                cmd.op      = leb_pkg::OP_DEL_INIT;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_CLEAR: begin
              if (!st.len_zero) begin
                cmd.op      = leb_pkg::OP_CLEAR;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_LEFT: begin
              if (!st.cur_zero) begin
                cmd.op      = leb_pkg::OP_LEFT;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_RIGHT: begin
              if (!st.cur_ge_len) begin
                cmd.op      = leb_pkg::OP_RIGHT;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_HOME: begin
              if (!st.cur_zero) begin
                cmd.op      = leb_pkg::OP_HOME;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_END: begin
              if (!st.cur_ge_len) begin
                cmd.op      = leb_pkg::OP_END;
                cmd.ign_val = 1'b0;
              end
            end
            leb_pkg::KIND_WLEFT, leb_pkg::KIND_WRIGHT: cmd.ign_we = 1'b0;
            leb_pkg::KIND_ACCEPT, leb_pkg::KIND_CANCEL: begin
              cmd.op      = leb_pkg::OP_STOP;
              cmd.ign_val = 1'b0;
            end
            default: cmd.ign_val = 1'b1;
          endcase
        end
      end
      leb_pkg::S_UP_CHK: begin
        cmd.op = st.idx_gt_cur ? leb_pkg::OP_UP_RD : leb_pkg::OP_INS_FIN;
      end
      leb_pkg::S_UP_WR: cmd.op = leb_pkg::OP_UP_WR;
      leb_pkg::S_DN_CHK: begin
        if (st.idx_lt_len) begin
          cmd.op = leb_pkg::OP_DN_RD;
        end else begin
          cmd.op = (st.kind == leb_pkg::KIND_BSPACE) ? leb_pkg::OP_BS_FIN
                                                     : leb_pkg::OP_DEL_FIN;
        end
      end
      leb_pkg::S_DN_WR: cmd.op = leb_pkg::OP_DN_WR;
      leb_pkg::S_SK1, leb_pkg::S_SK2: begin
        if (st.skip_can) cmd.op = leb_pkg::OP_SK_RD;
      end
      leb_pkg::S_SK1C: cmd.op = leb_pkg::OP_SK_STEP;
      leb_pkg::S_SK2C: begin
        if (!st.skip1_match) cmd.op = leb_pkg::OP_SK_STEP;
      end
      leb_pkg::S_WFIN: begin
        cmd.ign_we  = 1'b1;
        cmd.ign_val = st.cur_eq_old;
      end
      leb_pkg::S_STATUS: begin
        if (st.out_free) cmd.op = leb_pkg::OP_EMIT_ST;
      end
      leb_pkg::S_ST_RD: cmd.op = leb_pkg::OP_ST_RD;
      leb_pkg::S_ST_EMIT: begin
        if (st.out_free) cmd.op = leb_pkg::OP_EMIT_CH;
      end
      default: cmd.op = leb_pkg::OP_NONE;
    endcase
  end

endmodule

/* src/leb_dp.sv */
// Datapath: line memory, length, cursor, walk index and the result register.
module leb_dp #(
  parameter int MAX_LINE = leb_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  leb_pkg::cmd_t                 cmd,
  output leb_pkg::stat_t                st,
  input  leb_pkg::cfg_t                 cfg,
  input  logic [leb_pkg::KIND_W-1:0]    in_kind,
  input  logic [leb_pkg::CODE_W-1:0]    in_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_line,
  output logic [leb_pkg::CODE_W-1:0]    out_char_out,
  output logic [leb_pkg::POS_W-1:0]     out_position,
  output logic                          out_last,
  output logic [leb_pkg::LEN_W-1:0]     out_line_length,
  output logic [leb_pkg::LEN_W-1:0]     out_cursor_pos,
  output logic                          out_ignored
);

  localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam logic [leb_pkg::LEN_W-1:0] MaxLen = leb_pkg::LEN_W'(MAX_LINE);
  localparam logic [leb_pkg::LEN_W-1:0] One    = leb_pkg::LEN_W'(1);

  logic [leb_pkg::CODE_W-1:0] mem [MAX_LINE];

  logic [leb_pkg::KIND_W-1:0] kind_r;
  logic [leb_pkg::CODE_W-1:0] code_r;
  logic [leb_pkg::LEN_W-1:0]  old_cur_r;
  logic [leb_pkg::LEN_W-1:0]  idx_r, idx_nxt;
  logic [leb_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic [leb_pkg::LEN_W-1:0]  cur_r, cur_nxt;
  logic                       active_r, active_nxt;
  logic                       ign_r;
  logic [leb_pkg::CODE_W-1:0] rdata_r;

  logic                       out_valid_r;
  logic                       out_is_line_r;
  logic [leb_pkg::CODE_W-1:0] out_char_r;
  logic [leb_pkg::POS_W-1:0]  out_pos_r;
  logic                       out_last_r;
  logic [leb_pkg::LEN_W-1:0]  out_len_r;
  logic [leb_pkg::LEN_W-1:0]  out_cur_r;
  logic                       out_ign_r;

  logic [leb_pkg::LEN_W-1:0]  limit;
  logic [leb_pkg::LEN_W-1:0]  rd_addr, wr_addr;
  logic                       rd_en, wr_en;
  logic [leb_pkg::CODE_W-1:0] wr_data;
  logic [leb_pkg::CODE_W-1:0] code_conv;
  logic [leb_pkg::CODE_W-1:0] char_map;
  logic                       go_left;
  logic                       is_space;
  logic                       out_free;
  logic                       emit;

  assign limit    = (cfg.max_length > MaxLen) ? MaxLen : cfg.max_length;
  assign go_left  = (kind_r == leb_pkg::KIND_WLEFT);
  assign is_space = (rdata_r == leb_pkg::SPACE_CODE);
  assign out_free = !out_valid_r || out_ready;
  assign emit     = (cmd.op == leb_pkg::OP_EMIT_ST) || (cmd.op == leb_pkg::OP_EMIT_CH);

  assign code_conv = (cfg.caps_lock && code_r > leb_pkg::LOWER_LO && code_r < leb_pkg::LOWER_HI)
                     ? code_r - leb_pkg::SPACE_CODE : code_r;
  assign char_map  = (cfg.byte_mode && rdata_r > leb_pkg::BYTE_MAX) ? leb_pkg::QMARK_CODE
                                                                     : rdata_r;

  always_comb begin
    st.kind        = kind_r;
    st.active      = active_r;
    st.len_zero    = (len_r == '0);
    st.cur_zero    = (cur_r == '0);
    st.cur_ge_len  = (cur_r >= len_r);
    st.ins_bad     = (len_r >= limit) || (code_r < leb_pkg::PRINT_MIN)
                     || (code_r > leb_pkg::CODE_MAX);
    st.idx_gt_cur  = (idx_r > cur_r);
    st.idx_lt_len  = (idx_r < len_r);
    st.idx_last    = (idx_r + One == len_r);
    st.skip_can    = go_left ? (cur_r != '0) : (cur_r < len_r);
    // left skips spaces first, right skips the word first
    st.skip1_match = go_left ? is_space : !is_space;
    st.cur_eq_old  = (cur_r == old_cur_r);
    st.out_free    = out_free;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rdata_r;
    case (cmd.op)
      leb_pkg::OP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_r - One;
      end
      leb_pkg::OP_DN_RD, leb_pkg::OP_ST_RD: rd_en = 1'b1;
      leb_pkg::OP_SK_RD: begin
        rd_en   = 1'b1;
        rd_addr = go_left ? cur_r - One : cur_r;
      end
      leb_pkg::OP_UP_WR: wr_en = 1'b1;
      leb_pkg::OP_DN_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - One;
      end
      leb_pkg::OP_INS_FIN: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = code_conv;
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[rd_addr[AW-1:0]];
  end

  // line state updates
  always_comb begin
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    active_nxt = active_r;
    case (cmd.op)
      leb_pkg::OP_START: begin
        active_nxt = 1'b1;
        len_nxt    = '0;
        cur_nxt    = '0;
      end
      leb_pkg::OP_CLEAR: begin
        len_nxt = '0;
        cur_nxt = '0;
      end
      leb_pkg::OP_LEFT:     cur_nxt = cur_r - One;
      leb_pkg::OP_RIGHT:    cur_nxt = cur_r + One;
      leb_pkg::OP_HOME:     cur_nxt = '0;
      leb_pkg::OP_END:      cur_nxt = len_r;
      leb_pkg::OP_INS_INIT: idx_nxt = len_r;
      leb_pkg::OP_INS_FIN: begin
        cur_nxt = cur_r + One;
        len_nxt = len_r + One;
      end
      leb_pkg::OP_BS_INIT:  idx_nxt = cur_r;
      leb_pkg::OP_DEL_INIT: idx_nxt = cur_r + One;
      leb_pkg::OP_BS_FIN: begin
        cur_nxt = cur_r - One;
        len_nxt = len_r - One;
      end
      leb_pkg::OP_DEL_FIN:  len_nxt = len_r - One;
      leb_pkg::OP_UP_WR:    idx_nxt = idx_r - One;
      leb_pkg::OP_DN_WR:    idx_nxt = idx_r + One;
      leb_pkg::OP_SK_STEP:  cur_nxt = go_left ? cur_r - One : cur_r + One;
      leb_pkg::OP_STOP: begin
        active_nxt = 1'b0;
        idx_nxt    = '0;
      end
      leb_pkg::OP_EMIT_CH:  idx_nxt = idx_r + One;
      default:              idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      cur_r    <= '0;
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      len_r    <= len_nxt;
      cur_r    <= cur_nxt;
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == leb_pkg::OP_LOAD) begin
      kind_r    <= in_kind;
      code_r    <= in_code;
      old_cur_r <= cur_r;
    end
    if (cmd.ign_we) ign_r <= cmd.ign_val;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_len_r <= len_r;
      out_cur_r <= cur_r;
      if (cmd.op == leb_pkg::OP_EMIT_CH) begin
        out_is_line_r <= 1'b1;
        out_char_r    <= char_map;
        out_pos_r     <= idx_r[leb_pkg::POS_W-1:0];
        out_last_r    <= st.idx_last;
        out_ign_r     <= 1'b0;
      end else begin
        out_is_line_r <= 1'b0;
        out_char_r    <= '0;
        out_pos_r     <= '0;
        out_last_r    <= 1'b1;
        out_ign_r     <= ign_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_line     = out_is_line_r;
  assign out_char_out    = out_char_r;
  assign out_position    = out_pos_r;
  assign out_last        = out_last_r;
  assign out_line_length = out_len_r;
  assign out_cursor_pos  = out_cur_r;
  assign out_ignored     = out_ign_r;

  a_cur_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor beyond line end");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= MaxLen) else $error("line length beyond capacity");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_addr < MaxLen)) else $error("line write out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free) else $error("result overwritten before taken");

  a_rd_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_addr < len_r)) else $error("line read past length");

endmodule

/* src/line_edit_buffer.sv */
// Line edit buffer top level: configuration registers, controller and datapath.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    in_kind, in_code
//   out      out  out_valid/out_ready  out_is_line, out_char_out, out_position, out_last,
//                                      out_line_length, out_cursor_pos, out_ignored
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A key is accepted, then decoded, then does its work on the line memory, then loads the
// status result: insert moves each character from the cursor on up one place and writes
// the new one, backspace/delete move each character after the removed one down, word skip
// reads each character passed; accept/cancel instead streams the line one character at a
// time. The status result then waits in the output register; the next key is taken meanwhile.
// Reset is synchronous; line memory contents are not cleared, but length, cursor, walk index and active flag are.
// A stalled out_ready holds the sequence at its next emit step.
module line_edit_buffer #(
  parameter int MAX_LINE = leb_pkg::MAX_LINE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [leb_pkg::KIND_W-1:0]    in_kind,
  input  logic [leb_pkg::CODE_W-1:0]    in_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_line,
  output logic [leb_pkg::CODE_W-1:0]    out_char_out,
  output logic [leb_pkg::POS_W-1:0]     out_position,
  output logic                          out_last,
  output logic [leb_pkg::LEN_W-1:0]     out_line_length,
  output logic [leb_pkg::LEN_W-1:0]     out_cursor_pos,
  output logic                          out_ignored,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [leb_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [leb_pkg::LEN_W-1:0]     cfg_data
);

  leb_pkg::cfg_t  cfg_r;
  leb_pkg::cmd_t  cmd;
  leb_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length <= leb_pkg::MAX_LEN_RST;
      cfg_r.caps_lock  <= 1'b0;
      cfg_r.byte_mode  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        leb_pkg::CFG_MAX_LENGTH: cfg_r.max_length <= cfg_data;
        leb_pkg::CFG_CAPS_LOCK:  cfg_r.caps_lock  <= cfg_data[0];
        leb_pkg::CFG_BYTE_MODE:  cfg_r.byte_mode  <= cfg_data[0];
        default:                 cfg_r.byte_mode  <= cfg_r.byte_mode;
      endcase
    end
  end

  leb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  leb_dp #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg             (cfg_r),
    .in_kind         (in_kind),
    .in_code         (in_code),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_line     (out_is_line),
    .out_char_out    (out_char_out),
    .out_position    (out_position),
    .out_last        (out_last),
    .out_line_length (out_line_length),
    .out_cursor_pos  (out_cursor_pos),
    .out_ignored     (out_ignored)
  );

endmodule

/* test/tb_top.sv */
// Testbench for line_edit_buffer: key streams checked against a behavioral line editor.
module tb_top;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 11;
  localparam int PHASES = 8;
  localparam int RANDOM_PER_PHASE = 31;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [leb_pkg::KIND_W-1:0] KIND_UNUSED = 4'd13;
  localparam logic [leb_pkg::KIND_W-1:0] KIND_TOP = 4'd15;

  typedef struct packed {
    logic [leb_pkg::KIND_W-1:0] kind;
    logic [leb_pkg::CODE_W-1:0] code;
  } key_req_t;

  typedef struct packed {
    logic                       is_line;
    logic [leb_pkg::CODE_W-1:0] ch;
    logic [leb_pkg::POS_W-1:0]  pos;
    logic                       last;
    logic [leb_pkg::LEN_W-1:0]  len;
    logic [leb_pkg::LEN_W-1:0]  cur;
    logic                       ign;
  } line_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [leb_pkg::KIND_W-1:0] in_kind = '0;
  logic [leb_pkg::CODE_W-1:0] in_code = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       out_is_line;
  logic [leb_pkg::CODE_W-1:0] out_char_out;
  logic [leb_pkg::POS_W-1:0]  out_position;
  logic                       out_last;
  logic [leb_pkg::LEN_W-1:0]  out_line_length;
  logic [leb_pkg::LEN_W-1:0]  out_cursor_pos;
  logic                       out_ignored;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [leb_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [leb_pkg::LEN_W-1:0]  cfg_data = '0;

  // handshake seen at the last rising edge
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;

  key_req_t     key_q[$];
  line_result_t expected_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int keys_queued = 0;
  int keys_taken = 0;
  int chars_seen = 0;
  int status_seen = 0;

  // editor state as the block should hold it
  logic [leb_pkg::CODE_W-1:0] mdl_line [0:63];
  logic [leb_pkg::LEN_W-1:0]  mdl_len = '0;
  logic [leb_pkg::LEN_W-1:0]  mdl_cur = '0;
  logic                       mdl_active = 1'b0;
  logic [leb_pkg::LEN_W-1:0]  reg_max_len = leb_pkg::MAX_LEN_RST;
  logic                       reg_caps = 1'b0;
  logic                       reg_bytes = 1'b0;

  line_edit_buffer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_code(in_code),
    .out_valid(out_valid), .out_ready(out_ready), .out_is_line(out_is_line),
    .out_char_out(out_char_out), .out_position(out_position), .out_last(out_last),
    .out_line_length(out_line_length), .out_cursor_pos(out_cursor_pos),
    .out_ignored(out_ignored),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  task automatic push_status(input logic ign);
    line_result_t r;
    r.is_line = 1'b0;
    r.ch = '0;
    r.pos = '0;
    r.last = 1'b1;
    r.len = mdl_len;
    r.cur = mdl_cur;
    r.ign = ign;
    expected_q.push_back(r);
  endtask

  // Applies one key to the editor state and queues the results it must produce.
  task automatic edit_line(input logic [leb_pkg::KIND_W-1:0] kind,
                           input logic [leb_pkg::CODE_W-1:0] code);
    logic [leb_pkg::LEN_W-1:0]  lim;
    logic [leb_pkg::LEN_W-1:0]  prev_cur;
    logic [leb_pkg::CODE_W-1:0] c;
    logic                       ign;
    int                         i;
    line_result_t               r;
    lim = (reg_max_len > leb_pkg::MAX_LEN_RST) ? leb_pkg::MAX_LEN_RST : reg_max_len;
    prev_cur = mdl_cur;
    c = code;
    ign = 1'b0;
    if (kind == leb_pkg::KIND_START) begin
      mdl_active = 1'b1;
      mdl_len = '0;
      mdl_cur = '0;
      push_status(1'b0);
    end else if (!mdl_active || kind > leb_pkg::KIND_START) begin
      push_status(1'b1);
    end else if (kind == leb_pkg::KIND_ACCEPT || kind == leb_pkg::KIND_CANCEL) begin
      mdl_active = 1'b0;
      if (mdl_len == 0) begin
        push_status(1'b0);
      end else begin
        for (i = 0; i < mdl_len; i++) begin
          r.is_line = 1'b1;
          r.ch = (reg_bytes && mdl_line[i] > leb_pkg::BYTE_MAX) ? leb_pkg::QMARK_CODE
                                                                : mdl_line[i];
          r.pos = i[leb_pkg::POS_W-1:0];
          r.last = (i + 1 == mdl_len);
          r.len = mdl_len;
          r.cur = mdl_cur;
          r.ign = 1'b0;
          expected_q.push_back(r);
        end
      end
    end else begin
      case (kind)
        leb_pkg::KIND_INSERT: begin
          if (mdl_len >= lim || c < leb_pkg::PRINT_MIN || c > leb_pkg::CODE_MAX) begin
            ign = 1'b1;
          end else begin
            if (reg_caps && c > leb_pkg::LOWER_LO && c < leb_pkg::LOWER_HI) begin
              c = c - leb_pkg::SPACE_CODE;
            end
            for (i = int'(mdl_len); i > mdl_cur; i--) mdl_line[i] = mdl_line[i-1];
            mdl_line[mdl_cur] = c;
            mdl_cur++;
            mdl_len++;
          end
        end
        leb_pkg::KIND_BSPACE: begin
          if (mdl_len == 0 || mdl_cur == 0) begin
            ign = 1'b1;
          end else begin
            for (i = int'(mdl_cur); i < mdl_len; i++) mdl_line[i-1] = mdl_line[i];
            mdl_cur--;
            mdl_len--;
          end
        end
        leb_pkg::KIND_DELETE: begin
          if (mdl_len == 0 || mdl_cur >= mdl_len) begin
            ign = 1'b1;
          end else begin
            for (i = int'(mdl_cur); i + 1 < mdl_len; i++) mdl_line[i] = mdl_line[i+1];
            mdl_len--;
          end
        end
        leb_pkg::KIND_CLEAR: begin
          if (mdl_len == 0) begin
            ign = 1'b1;
          end else begin
            mdl_len = '0;
            mdl_cur = '0;
          end
        end
        leb_pkg::KIND_LEFT: begin
          if (mdl_cur == 0) ign = 1'b1;
          else mdl_cur--;
        end
        leb_pkg::KIND_RIGHT: begin
          if (mdl_cur >= mdl_len) ign = 1'b1;
          else mdl_cur++;
        end
        leb_pkg::KIND_HOME: begin
          if (mdl_cur == 0) ign = 1'b1;
          else mdl_cur = '0;
        end
        leb_pkg::KIND_END: begin
          if (mdl_cur >= mdl_len) ign = 1'b1;
          else mdl_cur = mdl_len;
        end
        leb_pkg::KIND_WLEFT: begin
          // skip spaces, then the word before them
          while (mdl_cur > 0 && mdl_line[mdl_cur-1] == leb_pkg::SPACE_CODE) mdl_cur--;
          while (mdl_cur > 0 && mdl_line[mdl_cur-1] != leb_pkg::SPACE_CODE) mdl_cur--;
          ign = (mdl_cur == prev_cur);
        end
        leb_pkg::KIND_WRIGHT: begin
          while (mdl_cur < mdl_len && mdl_line[mdl_cur] != leb_pkg::SPACE_CODE) mdl_cur++;
          while (mdl_cur < mdl_len && mdl_line[mdl_cur] == leb_pkg::SPACE_CODE) mdl_cur++;
          ign = (mdl_cur == prev_cur);
        end
        default: begin
          ign = 1'b1;
        end
      endcase
      push_status(ign);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Monitor: tracks register writes and accepted keys, checks every result.
  always @(posedge clk) begin : monitor
    line_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      cfg_took <= cfg_valid && cfg_ready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          leb_pkg::CFG_MAX_LENGTH: reg_max_len = cfg_data;
          leb_pkg::CFG_CAPS_LOCK:  reg_caps = cfg_data[0];
          leb_pkg::CFG_BYTE_MODE:  reg_bytes = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        edit_line(in_kind, in_code);
        keys_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending: is_line=%0b char=0x%0h",
                 out_is_line, out_char_out);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("is_line", 32'(want.is_line), 32'(out_is_line));
          check_field("char_out", 32'(want.ch), 32'(out_char_out));
          check_field("position", 32'(want.pos), 32'(out_position));
          check_field("last", 32'(want.last), 32'(out_last));
          check_field("line_length", 32'(want.len), 32'(out_line_length));
          check_field("cursor_pos", 32'(want.cur), 32'(out_cursor_pos));
          check_field("ignored", 32'(want.ign), 32'(out_ignored));
          if (want.is_line) chars_seen++;
          else status_seen++;
        end
      end
    end
  end

  // Driver: presents queued keys and toggles out_ready.
  always @(negedge clk) begin : driver
    key_req_t k;
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (key_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          k = key_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= k.kind;
          in_code <= k.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_key(input logic [leb_pkg::KIND_W-1:0] kind,
                          input logic [leb_pkg::CODE_W-1:0] code);
    key_req_t k;
    k.kind = kind;
    k.code = code;
    key_q.push_back(k);
    keys_queued++;
  endtask

  function automatic logic [leb_pkg::CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(99);
    if (r < 25) return leb_pkg::SPACE_CODE;
    if (r < 55) return leb_pkg::CODE_W'($urandom_range(leb_pkg::LOWER_HI, leb_pkg::LOWER_LO));
    if (r < 80) return leb_pkg::CODE_W'($urandom_range(8'h7e, 8'h21));
    if (r < 92) return leb_pkg::CODE_W'($urandom_range(leb_pkg::CODE_MAX, 21'h100));
    return leb_pkg::CODE_W'($urandom);
  endfunction

  // start, a run of edits with mostly printable text, then accept or cancel
  task automatic queue_session();
    int n;
    int j;
    push_key(leb_pkg::KIND_START, leb_pkg::CODE_W'($urandom));
    n = $urandom_range(40, 1);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(99) < 55) begin
        push_key(leb_pkg::KIND_INSERT, pick_code());
      end else begin
        push_key(leb_pkg::KIND_W'(leb_pkg::KIND_BSPACE + $urandom_range(8)),
                 leb_pkg::CODE_W'($urandom));
      end
    end
    push_key($urandom_range(1) ? leb_pkg::KIND_ACCEPT : leb_pkg::KIND_CANCEL,
             leb_pkg::CODE_W'($urandom));
  endtask

  task automatic write_reg(input logic [leb_pkg::CIDX_W-1:0] idx,
                           input logic [leb_pkg::LEN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int j;
    int target;
    logic [leb_pkg::LEN_W-1:0] max_len;
    logic caps;
    logic bytes;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      case (p)
        0: begin max_len = 7'd64;  caps = 1'b0; bytes = 1'b0; end
        1: begin max_len = 7'd127; caps = 1'b1; bytes = 1'b1; end
        2: begin max_len = 7'd0;   caps = 1'b0; bytes = 1'b1; end
        3: begin max_len = 7'd7;   caps = 1'b1; bytes = 1'b0; end
        4: begin max_len = 7'd64;  caps = 1'b1; bytes = 1'b1; end
        5: begin max_len = 7'd1;   caps = 1'b0; bytes = 1'b0; end
        6: begin max_len = 7'd20;  caps = 1'b1; bytes = 1'b0; end
        default: begin max_len = 7'd65; caps = 1'b0; bytes = 1'b1; end
      endcase
      write_reg(leb_pkg::CFG_MAX_LENGTH, max_len);
      write_reg(leb_pkg::CFG_CAPS_LOCK, {{(leb_pkg::LEN_W-1){1'b0}}, caps});
      write_reg(leb_pkg::CFG_BYTE_MODE, {{(leb_pkg::LEN_W-1){1'b0}}, bytes});
      if (p == 0) begin
        // keys while idle, then edge cases of an empty and a short line
        push_key(leb_pkg::KIND_INSERT, 21'h78);
        push_key(KIND_TOP, 21'h1fffff);
        push_key(leb_pkg::KIND_ACCEPT, '0);
        push_key(leb_pkg::KIND_START, '0);
        push_key(leb_pkg::KIND_BSPACE, '0);
        push_key(leb_pkg::KIND_DELETE, '0);
        push_key(leb_pkg::KIND_CLEAR, '0);
        push_key(leb_pkg::KIND_LEFT, '0);
        push_key(leb_pkg::KIND_WLEFT, '0);
        push_key(leb_pkg::KIND_INSERT, '0);
        push_key(leb_pkg::KIND_INSERT, leb_pkg::PRINT_MIN - 1);
        push_key(leb_pkg::KIND_INSERT, leb_pkg::CODE_MAX + 1);
        push_key(leb_pkg::KIND_INSERT, 21'h1fffff);
        push_key(leb_pkg::KIND_INSERT, 21'h61);
        push_key(leb_pkg::KIND_INSERT, leb_pkg::PRINT_MIN);
        push_key(leb_pkg::KIND_INSERT, leb_pkg::CODE_MAX);
        push_key(leb_pkg::KIND_HOME, '0);
        push_key(leb_pkg::KIND_WRIGHT, '0);
        push_key(leb_pkg::KIND_END, '0);
        push_key(leb_pkg::KIND_WLEFT, '0);
        push_key(leb_pkg::KIND_BSPACE, '0);
        push_key(KIND_UNUSED, '0);
        push_key(leb_pkg::KIND_START, '0);
        push_key(leb_pkg::KIND_INSERT, 21'h71);
        push_key(leb_pkg::KIND_CANCEL, '0);
        push_key(leb_pkg::KIND_START, '0);
        push_key(leb_pkg::KIND_ACCEPT, '0);
      end
      if (p == 1) begin
        // overfill the line so the longest stream comes out
        push_key(leb_pkg::KIND_START, '0);
        for (j = 0; j < 70; j++) push_key(leb_pkg::KIND_INSERT, pick_code() | 21'h40);
        push_key(leb_pkg::KIND_ACCEPT, '0);
      end
      target = keys_queued + RANDOM_PER_PHASE;
      while (keys_queued < target) begin
        if ($urandom_range(9) < 8) begin
          queue_session();
        end else begin
          push_key(leb_pkg::KIND_W'($urandom_range(KIND_TOP)), leb_pkg::CODE_W'($urandom));
        end
      end
      do @(negedge clk); while (keys_taken != keys_queued || expected_q.size() != 0);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Covered %0d keys over %0d register settings and four handshake mixes.",
             keys_taken, PHASES);
    $display("Checked %0d streamed characters and %0d status results.",
             chars_seen, status_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd2 * CLK_HALF * 64'd1_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
